/* src/bezier_arc_length_sampler_core_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the Bezier arc-length sampler
// Shared wrappers for concurrent checks clocked by clock, held off in reset.
// ----------------------------------------------------------------------------
`ifndef BEZIER_ARC_LENGTH_SAMPLER_CORE_MACROS_SVH
`define BEZIER_ARC_LENGTH_SAMPLER_CORE_MACROS_SVH

// same-cycle implication
`define BZAL_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bzal check failed");

// next-cycle implication
`define BZAL_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bzal check failed");

`endif

/* src/bzal_pkg.sv */
// ----------------------------------------------------------------------------
// bzal_pkg
// Widths, register indexes and control structs of the arc-length sampler.
// ----------------------------------------------------------------------------
package bzal_pkg;

   localparam int LUT_STEPS  = 256;
   localparam int LOG_STEPS  = $clog2(LUT_STEPS);
   localparam int IDX_W      = $clog2(LUT_STEPS + 1);
   localparam int STEP_SHIFT = 16 - LOG_STEPS;
   localparam int COORD_W    = 32;
   localparam int PW         = 34;
   localparam int ROOT_W     = 35;
   localparam int LEN_W      = 40;
   localparam int U_W        = 17;
   localparam int CSR_IW     = 4;

   localparam logic [U_W-1:0] ONE_Q16 = 17'h10000;

   localparam logic [CSR_IW-1:0] REG_START_X = 4'd0;
   localparam logic [CSR_IW-1:0] REG_START_Y = 4'd1;
   localparam logic [CSR_IW-1:0] REG_OUT_TX  = 4'd2;
   localparam logic [CSR_IW-1:0] REG_OUT_TY  = 4'd3;
   localparam logic [CSR_IW-1:0] REG_END_X   = 4'd4;
   localparam logic [CSR_IW-1:0] REG_END_Y   = 4'd5;
   localparam logic [CSR_IW-1:0] REG_IN_TX   = 4'd6;
   localparam logic [CSR_IW-1:0] REG_IN_TY   = 4'd7;

   typedef struct packed {
      logic signed [COORD_W-1:0] start_x;
      logic signed [COORD_W-1:0] start_y;
      logic signed [COORD_W-1:0] out_tangent_x;
      logic signed [COORD_W-1:0] out_tangent_y;
      logic signed [COORD_W-1:0] end_x;
      logic signed [COORD_W-1:0] end_y;
      logic signed [COORD_W-1:0] in_tangent_x;
      logic signed [COORD_W-1:0] in_tangent_y;
   } seg_type;

   typedef struct packed {
      logic           go;
      logic [U_W-1:0] u;
   } eval_req_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_sts_type;

   typedef struct packed {
      logic          go;
      logic [PW-1:0] dx;
      logic [PW-1:0] dy;
   } root_req_type;

endpackage

/* src/bezier_arc_length_sampler_core.sv */
// ----------------------------------------------------------------------------
// bezier_arc_length_sampler_core
// Cubic Bezier arc-length sampler: builds a 257-entry cumulative length
// table on the first word after configuration, then maps a distance to a
// curve parameter by binary search and division, and evaluates the point.
//
//   channel  direction  handshake             word
//   req_     in         req_valid/req_stall   target_distance
//   rsp_     out        rsp_valid/rsp_stall   point_x, point_y, curve_param,
//                                             total_length
//   csr_     in         csr_valid/csr_ready   csr_index, csr_wdata
//
// A query runs up to nine table probes (S_SRD then S_SCMP), a bit-serial
// 17-bit divider and a point evaluation of 12 lerps (multiply, then add).
// A table build adds 256 steps, each a point evaluation and a chord root.
// Reset is synchronous; it and any segment register write invalidate the table.
// req_stall is high while a word is in work; the result register frees the
// sequencer, which waits only if a prior result is still stalled.
// ----------------------------------------------------------------------------
module bezier_arc_length_sampler_core import bzal_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [LEN_W-1:0]          req_target_distance,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [COORD_W-1:0] rsp_point_x,
   output logic signed [COORD_W-1:0] rsp_point_y,
   output logic [U_W-1:0]            rsp_curve_param,
   output logic [LEN_W-1:0]          rsp_total_length,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_IW-1:0]         csr_index,
   input  logic [COORD_W-1:0]        csr_wdata
);

`include "bezier_arc_length_sampler_core_macros.svh"

   typedef enum logic [11:0] {
      S_IDLE  = 12'b000000000001,
      S_BEVAL = 12'b000000000010,
      S_BROOT = 12'b000000000100,
      S_SSTRT = 12'b000000001000,
      S_SRD   = 12'b000000010000,
      S_SCMP  = 12'b000000100000,
      S_PREV  = 12'b000001000000,
      S_NEXT  = 12'b000010000000,
      S_DIV   = 12'b000100000000,
      S_UCALC = 12'b001000000000,
      S_PEVAL = 12'b010000000000,
      S_EMIT  = 12'b100000000000
   } state_type;

   state_type            state_ff, state_in;
   seg_type              seg_ff, seg_in;
   logic                 table_valid_ff, table_valid_in;
   logic [LEN_W-1:0]     target_ff, target_in;
   logic [LEN_W-1:0]     total_ff, total_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [IDX_W-1:0]     lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic [LEN_W-1:0]     prev_ff, prev_in, den_ff, den_in;
   logic [LEN_W+1:0]     rem_ff, rem_in;
   logic [U_W-1:0]       q_ff, q_in, u_ff, u_in;
   logic [4:0]           div_cnt_ff, div_cnt_in;
   logic signed [PW-1:0] px_ff, px_in, py_ff, py_in;

   logic                      out_valid_ff, out_valid_in;
   logic signed [COORD_W-1:0] out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic [U_W-1:0]            out_u_ff, out_u_in;
   logic [LEN_W-1:0]          out_len_ff, out_len_in;

   logic [LEN_W-1:0] arc_mem [0:LUT_STEPS];
   logic [LEN_W-1:0] rd_data_ff;
   logic             mem_we;
   logic [IDX_W-1:0] mem_wa, mem_ra;
   logic [LEN_W-1:0] mem_wd;

   eval_req_type         eval_req;
   unit_sts_type         eval_sts, root_sts;
   root_req_type         root_req;
   logic signed [PW-1:0] ev_x, ev_y;
   logic [ROOT_W-1:0]    root;

   logic                 req_take, out_free;
   logic [LEN_W-1:0]     tgt_clamp;
   logic [LEN_W:0]       len_sum;
   logic [IDX_W:0]       mid_sum;
   logic [IDX_W-1:0]     idx_next, lo_m1;
   logic signed [PW:0]   dxs, dys;
   logic [LEN_W+1:0]     rem_cur;
   logic [U_W+LOG_STEPS-1:0] u_sum;
   logic [U_W-1:0]       u_calc;

   function automatic logic signed [COORD_W-1:0] sat32(input logic signed [PW-1:0] v);
      logic signed [COORD_W-1:0] r;
      if (v[PW-1:COORD_W-1] == '0 || v[PW-1:COORD_W-1] == '1) begin
         r = COORD_W'(v);
      end else if (v[PW-1]) begin
         r = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(COORD_W-1){1'b1}}};
      end
      return r;
   endfunction

   bzal_eval u_eval (
      .clock (clock),
      .reset (reset),
      .seg   (seg_ff),
      .req   (eval_req),
      .sts   (eval_sts),
      .pt_x  (ev_x),
      .pt_y  (ev_y)
   );

   bzal_root u_root (
      .clock (clock),
      .reset (reset),
      .req   (root_req),
      .sts   (root_sts),
      .root  (root)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign out_free  = !out_valid_ff || !rsp_stall;

   assign tgt_clamp = (target_ff > total_ff) ? total_ff : target_ff;
   assign len_sum   = (LEN_W+1)'(total_ff) + (LEN_W+1)'(root);
   assign mid_sum   = (IDX_W+1)'(lo_ff) + (IDX_W+1)'(hi_ff);
   assign idx_next  = idx_ff + IDX_W'(1);
   assign lo_m1     = lo_ff - IDX_W'(1);
   assign dxs       = (PW+1)'(ev_x) - (PW+1)'(px_ff);
   assign dys       = (PW+1)'(ev_y) - (PW+1)'(py_ff);
   assign rem_cur   = (div_cnt_ff == 5'd0) ? rem_ff : (rem_ff << 1);
   assign u_sum     = ((U_W+LOG_STEPS)'(lo_m1) << 16) + (U_W+LOG_STEPS)'(q_ff);
   assign u_calc    = (u_sum[U_W+LOG_STEPS-1:LOG_STEPS] > ONE_Q16) ? ONE_Q16 :
                      u_sum[U_W+LOG_STEPS-1:LOG_STEPS];

   always_comb begin
      seg_in         = seg_ff;
      table_valid_in = table_valid_ff;
      if (csr_valid && csr_ready) begin
         table_valid_in = 1'b0;
         case (csr_index)
            REG_START_X: seg_in.start_x       = csr_wdata;
            REG_START_Y: seg_in.start_y       = csr_wdata;
            REG_OUT_TX:  seg_in.out_tangent_x = csr_wdata;
            REG_OUT_TY:  seg_in.out_tangent_y = csr_wdata;
            REG_END_X:   seg_in.end_x         = csr_wdata;
            REG_END_Y:   seg_in.end_y         = csr_wdata;
            REG_IN_TX:   seg_in.in_tangent_x  = csr_wdata;
            REG_IN_TY:   seg_in.in_tangent_y  = csr_wdata;
            // drop writes beyond the register file
            default:     table_valid_in = table_valid_ff;
         endcase
      end

      state_in     = state_ff;
      target_in    = target_ff;
      total_in     = total_ff;
      idx_in       = idx_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      prev_in      = prev_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      q_in         = q_ff;
      u_in         = u_ff;
      div_cnt_in   = div_cnt_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_u_in     = out_u_ff;
      out_len_in   = out_len_ff;
      mem_we       = 1'b0;
      mem_wa       = '0;
      mem_wd       = '0;
      mem_ra       = lo_ff;
      eval_req     = '{go: 1'b0, u: '0};
      root_req     = '{go: 1'b0, dx: '0, dy: '0};

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               target_in = req_target_distance;
               if (table_valid_ff) begin
                  state_in = S_SSTRT;
               end else begin
                  // start a table build at the curve start
                  mem_we      = 1'b1;
                  total_in    = '0;
                  idx_in      = IDX_W'(1);
                  px_in       = PW'(seg_ff.start_x);
                  py_in       = PW'(seg_ff.start_y);
                  eval_req.go = 1'b1;
                  eval_req.u  = U_W'(1) << STEP_SHIFT;
                  state_in    = S_BEVAL;
               end
            end
         end
         S_BEVAL: begin
            if (eval_sts.done) begin
               root_req.go = 1'b1;
               root_req.dx = dxs[PW] ? PW'(-dxs) : PW'(dxs);
               root_req.dy = dys[PW] ? PW'(-dys) : PW'(dys);
               state_in    = S_BROOT;
            end
         end
         S_BROOT: begin
            if (root_sts.done) begin
               total_in = len_sum[LEN_W] ? {LEN_W{1'b1}} : len_sum[LEN_W-1:0];
               mem_we   = 1'b1;
               mem_wa   = idx_ff;
               mem_wd   = total_in;
               px_in    = ev_x;
               py_in    = ev_y;
               if (idx_ff == IDX_W'(LUT_STEPS)) begin
                  table_valid_in = 1'b1;
                  state_in       = S_SSTRT;
               end else begin
                  idx_in      = idx_next;
                  eval_req.go = 1'b1;
                  eval_req.u  = U_W'(idx_next) << STEP_SHIFT;
                  state_in    = S_BEVAL;
               end
            end
         end
         S_SSTRT: begin
            target_in = tgt_clamp;
            if (total_ff == '0 || tgt_clamp == '0) begin
               u_in        = '0;
               eval_req.go = 1'b1;
               state_in    = S_PEVAL;
            end else begin
               lo_in    = '0;
               hi_in    = IDX_W'(LUT_STEPS);
               state_in = S_SRD;
            end
         end
         S_SRD: begin
            if (lo_ff < hi_ff) begin
               mid_in   = mid_sum[IDX_W:1];
               mem_ra   = mid_sum[IDX_W:1];
               state_in = S_SCMP;
            end else begin
               mem_ra   = lo_m1;
               state_in = S_PREV;
            end
         end
         S_SCMP: begin
            if (rd_data_ff >= target_ff) begin
               hi_in = mid_ff;
            end else begin
               lo_in = mid_ff + IDX_W'(1);
            end
            state_in = S_SRD;
         end
         S_PREV: begin
            prev_in  = rd_data_ff;
            mem_ra   = lo_ff;
            state_in = S_NEXT;
         end
         S_NEXT: begin
            den_in     = rd_data_ff - prev_ff;
            rem_in     = (LEN_W+2)'(target_ff - prev_ff);
            q_in       = '0;
            div_cnt_in = '0;
            state_in   = (rd_data_ff == prev_ff) ? S_UCALC : S_DIV;
         end
         S_DIV: begin
            if (rem_cur >= (LEN_W+2)'(den_ff)) begin
               rem_in = rem_cur - (LEN_W+2)'(den_ff);
               q_in   = {q_ff[U_W-2:0], 1'b1};
            end else begin
               rem_in = rem_cur;
               q_in   = {q_ff[U_W-2:0], 1'b0};
            end
            div_cnt_in = div_cnt_ff + 5'd1;
            if (div_cnt_ff == 5'(U_W - 1)) begin
               state_in = S_UCALC;
            end
         end
         S_UCALC: begin
            u_in        = u_calc;
            eval_req.go = 1'b1;
            eval_req.u  = u_calc;
            state_in    = S_PEVAL;
         end
         S_PEVAL: begin
            if (eval_sts.done) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            // hold until the result register is free
            if (out_free) begin
               out_valid_in = 1'b1;
               out_x_in     = sat32(ev_x);
               out_y_in     = sat32(ev_y);
               out_u_in     = u_ff;
               out_len_in   = total_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         arc_mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= arc_mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         seg_ff         <= '0;
         table_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         seg_ff         <= seg_in;
         table_valid_ff <= table_valid_in;
         out_valid_ff   <= out_valid_in;
      end
      target_ff  <= target_in;
      total_ff   <= total_in;
      idx_ff     <= idx_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      mid_ff     <= mid_in;
      prev_ff    <= prev_in;
      den_ff     <= den_in;
      rem_ff     <= rem_in;
      q_ff       <= q_in;
      u_ff       <= u_in;
      div_cnt_ff <= div_cnt_in;
      px_ff      <= px_in;
      py_ff      <= py_in;
      out_x_ff   <= out_x_in;
      out_y_ff   <= out_y_in;
      out_u_ff   <= out_u_in;
      out_len_ff <= out_len_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_point_x      = out_x_ff;
   assign rsp_point_y      = out_y_ff;
   assign rsp_curve_param  = out_u_ff;
   assign rsp_total_length = out_len_ff;

   `BZAL_ASSERT_IMP(a_param_range, out_valid_ff, out_u_ff <= ONE_Q16)
   `BZAL_ASSERT_IMP(a_search_order, state_ff == S_SRD, lo_ff <= hi_ff)
   `BZAL_ASSERT_IMP(a_build_invalid, state_ff == S_BEVAL || state_ff == S_BROOT, !table_valid_ff)
   `BZAL_ASSERT_IMP(a_div_rem, state_ff == S_DIV && div_cnt_ff != 5'd0, rem_ff < (LEN_W+2)'(den_ff))
   `BZAL_ASSERT_NXT(a_build_step, state_ff == S_BROOT && root_sts.done && idx_ff != IDX_W'(LUT_STEPS), eval_sts.busy)

endmodule

/* src/bzal_eval.sv */
// ----------------------------------------------------------------------------
// bzal_eval
// De Casteljau point evaluator: one shared lerp unit, x axis then y axis.
// ----------------------------------------------------------------------------
module bzal_eval import bzal_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  seg_type              seg,
   input  eval_req_type         req,
   output unit_sts_type         sts,
   output logic signed [PW-1:0] pt_x,
   output logic signed [PW-1:0] pt_y
);

   typedef enum logic [2:0] {
      E_IDLE = 3'b001,
      E_MUL  = 3'b010,
      E_ADD  = 3'b100
   } eval_state_type;

   eval_state_type       state_ff, state_in;
   logic                 axis_ff, axis_in;
   logic [2:0]           step_ff, step_in;
   logic [U_W-1:0]       u_ff, u_in;
   logic signed [PW-1:0] w0_ff, w1_ff, w2_ff, w3_ff;
   logic signed [PW-1:0] w0_in, w1_in, w2_in, w3_in;
   logic signed [52:0]   prod_ff, prod_in;
   logic signed [PW-1:0] x_ff, x_in, y_ff, y_in;
   logic                 done_ff, done_in;

   logic signed [PW-1:0] lx0, lx1, lx2, lx3, ly0, ly1, ly2, ly3;
   logic signed [PW-1:0] a_sel, b_sel, lerp_res;
   logic signed [PW:0]   diff;
   logic signed [U_W:0]  u_s;
   logic signed [52:0]   shifted;

   assign lx0 = PW'(seg.start_x);
   assign lx1 = PW'(seg.start_x) + PW'(seg.out_tangent_x);
   assign lx2 = PW'(seg.end_x) + PW'(seg.in_tangent_x);
   assign lx3 = PW'(seg.end_x);
   assign ly0 = PW'(seg.start_y);
   assign ly1 = PW'(seg.start_y) + PW'(seg.out_tangent_y);
   assign ly2 = PW'(seg.end_y) + PW'(seg.in_tangent_y);
   assign ly3 = PW'(seg.end_y);

   always_comb begin
      case (step_ff)
         3'd1, 3'd4: begin
            a_sel = w1_ff;
            b_sel = w2_ff;
         end
         3'd2: begin
            a_sel = w2_ff;
            b_sel = w3_ff;
         end
         default: begin
            a_sel = w0_ff;
            b_sel = w1_ff;
         end
      endcase
   end

   assign diff     = (PW+1)'(b_sel) - (PW+1)'(a_sel);
   assign u_s      = {1'b0, u_ff};
   assign prod_in  = diff * u_s;
   assign shifted  = (prod_ff + 53'sd32768) >>> 16;
   assign lerp_res = a_sel + PW'(shifted);

   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      step_in  = step_ff;
      u_in     = u_ff;
      w0_in    = w0_ff;
      w1_in    = w1_ff;
      w2_in    = w2_ff;
      w3_in    = w3_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      done_in  = 1'b0;
      case (state_ff)
         E_IDLE: begin
            if (req.go) begin
               u_in     = req.u;
               axis_in  = 1'b0;
               step_in  = 3'd0;
               w0_in    = lx0;
               w1_in    = lx1;
               w2_in    = lx2;
               w3_in    = lx3;
               state_in = E_MUL;
            end
         end
         E_MUL: begin
            state_in = E_ADD;
         end
         E_ADD: begin
            case (step_ff)
               3'd1, 3'd4: w1_in = lerp_res;
               3'd2:       w2_in = lerp_res;
               default:    w0_in = lerp_res;
            endcase
            state_in = E_MUL;
            step_in  = step_ff + 3'd1;
            if (step_ff == 3'd5) begin
               step_in = 3'd0;
               if (!axis_ff) begin
                  // x done: load y control points
                  x_in    = lerp_res;
                  axis_in = 1'b1;
                  w0_in   = ly0;
                  w1_in   = ly1;
                  w2_in   = ly2;
                  w3_in   = ly3;
               end else begin
                  y_in     = lerp_res;
                  done_in  = 1'b1;
                  state_in = E_IDLE;
               end
            end
         end
         default: state_in = E_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= E_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      axis_ff <= axis_in;
      step_ff <= step_in;
      u_ff    <= u_in;
      w0_ff   <= w0_in;
      w1_ff   <= w1_in;
      w2_ff   <= w2_in;
      w3_ff   <= w3_in;
      prod_ff <= prod_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
   end

   assign sts.busy = (state_ff != E_IDLE);
   assign sts.done = done_ff;
   assign pt_x     = x_ff;
   assign pt_y     = y_ff;

endmodule

/* src/bzal_root.sv */
// ----------------------------------------------------------------------------
// bzal_root
// Chord length: sum of squares from 17x17 partial products, then a
// bit-serial integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module bzal_root import bzal_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  root_req_type      req,
   output unit_sts_type      sts,
   output logic [ROOT_W-1:0] root
);

   localparam int ACC_W  = 2 * ROOT_W;
   localparam int REM_W  = ROOT_W + 2;
   localparam int HALF_W = PW / 2;

   typedef enum logic [2:0] {
      R_IDLE = 3'b001,
      R_SQ   = 3'b010,
      R_RT   = 3'b100
   } root_state_type;

   root_state_type    state_ff, state_in;
   logic [5:0]        cnt_ff, cnt_in;
   logic [PW-1:0]     dx_ff, dx_in, dy_ff, dy_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [ROOT_W-1:0] res_ff, res_in;
   logic              done_ff, done_in;

   logic [HALF_W-1:0] ma, mb;
   logic [1:0]        sh_code;
   logic [PW-1:0]     pp;
   logic [ACC_W-1:0]  term;
   logic [REM_W+1:0]  rem_cur, trial;

   always_comb begin
      case (cnt_ff[2:0])
         3'd0: begin ma = dx_ff[HALF_W-1:0]; mb = dx_ff[HALF_W-1:0]; sh_code = 2'd0; end
         3'd1: begin ma = dx_ff[PW-1:HALF_W]; mb = dx_ff[HALF_W-1:0]; sh_code = 2'd1; end
         3'd2: begin ma = dx_ff[PW-1:HALF_W]; mb = dx_ff[PW-1:HALF_W]; sh_code = 2'd2; end
         3'd3: begin ma = dy_ff[HALF_W-1:0]; mb = dy_ff[HALF_W-1:0]; sh_code = 2'd0; end
         3'd4: begin ma = dy_ff[PW-1:HALF_W]; mb = dy_ff[HALF_W-1:0]; sh_code = 2'd1; end
         3'd5: begin ma = dy_ff[PW-1:HALF_W]; mb = dy_ff[PW-1:HALF_W]; sh_code = 2'd2; end
         default: begin ma = '0; mb = '0; sh_code = 2'd0; end
      endcase
   end

   assign pp = PW'(ma) * PW'(mb);

   always_comb begin
      case (sh_code)
         // cross term counts twice
         2'd1:    term = ACC_W'(pp) << (HALF_W + 1);
         2'd2:    term = ACC_W'(pp) << (2 * HALF_W);
         default: term = ACC_W'(pp);
      endcase
   end

   assign rem_cur = {rem_ff, acc_ff[ACC_W-1:ACC_W-2]};
   assign trial   = {2'b00, res_ff, 2'b01};

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      res_in   = res_ff;
      done_in  = 1'b0;
      case (state_ff)
         R_IDLE: begin
            if (req.go) begin
               dx_in    = req.dx;
               dy_in    = req.dy;
               acc_in   = '0;
               rem_in   = '0;
               res_in   = '0;
               cnt_in   = '0;
               state_in = R_SQ;
            end
         end
         R_SQ: begin
            acc_in = acc_ff + term;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd5) begin
               cnt_in   = '0;
               state_in = R_RT;
            end
         end
         R_RT: begin
            acc_in = acc_ff << 2;
            if (rem_cur >= trial) begin
               rem_in = REM_W'(rem_cur - trial);
               res_in = {res_ff[ROOT_W-2:0], 1'b1};
            end else begin
               rem_in = REM_W'(rem_cur);
               res_in = {res_ff[ROOT_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(ROOT_W - 1)) begin
               done_in  = 1'b1;
               state_in = R_IDLE;
            end
         end
         default: state_in = R_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= R_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff <= cnt_in;
      dx_ff  <= dx_in;
      dy_ff  <= dy_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      res_ff <= res_in;
   end

   assign sts.busy = (state_ff != R_IDLE);
   assign sts.done = done_ff;
   assign root     = res_ff;

endmodule
